// ----- rtl/core/sspr_pkg.sv -----
// Shared constants and control type for the sphere sheet pad remap block.
// No dependencies; used by sspr_remap and sphere_sheet_pad_remap.
`default_nettype none

package sspr_pkg;

    // fixed field widths
    localparam int COORD_BITS = 9;   // col, row
    localparam int DIM_BITS   = 9;   // map_width, map_height
    localparam int PAD_BITS   = 5;   // pad_size
    localparam int CFG_IDX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAD_SIZE   = 2'd2;

    // reset values
    localparam logic [DIM_BITS-1:0] RST_MAP_WIDTH  = 9'd256;
    localparam logic [DIM_BITS-1:0] RST_MAP_HEIGHT = 9'd128;
    localparam logic [PAD_BITS-1:0] RST_PAD_SIZE   = 5'd0;

    // action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // per-stage control that travels with each word
    typedef struct packed {
        logic valid;  // stage holds a word
        logic rd;     // read request, produces a result
        logic err;    // read with bad geometry or position
        logic wr;     // write that lands in the store
        logic pole;   // read crosses a pole: half-turn in longitude
    } t_ctl;

endpackage

`default_nettype wire

// ----- rtl/core/sspr_remap.sv -----
// Address remap pipeline: input register, column wrap / row mirror, pole shift,
// linear address. Depends on sspr_pkg.
`default_nettype none

module sspr_remap #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int MAX_PAD     = 16,
    parameter int SAMPLE_BITS = 32,
    parameter int ADDR_BITS   = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_en,
    input  wire                                 i_valid,
    input  wire                                 i_action,
    input  wire  [sspr_pkg::COORD_BITS-1:0]     i_col,
    input  wire  [sspr_pkg::COORD_BITS-1:0]     i_row,
    input  wire  [SAMPLE_BITS-1:0]              i_sample,
    input  wire  [sspr_pkg::DIM_BITS-1:0]       i_map_width,
    input  wire  [sspr_pkg::DIM_BITS-1:0]       i_map_height,
    input  wire  [sspr_pkg::PAD_BITS-1:0]       i_pad_size,
    output sspr_pkg::t_ctl                      o_ctl,
    output logic [ADDR_BITS-1:0]                o_addr,
    output logic [SAMPLE_BITS-1:0]              o_sample
);

    localparam int XW = sspr_pkg::COORD_BITS + 2;
    localparam int DW = sspr_pkg::DIM_BITS;
    localparam logic [31:0] LIM_W = 32'(MAX_WIDTH);
    localparam logic [31:0] LIM_H = 32'(MAX_HEIGHT);
    localparam logic [31:0] LIM_P = 32'(MAX_PAD);
    localparam logic [ADDR_BITS-1:0] ROW_STRIDE = ADDR_BITS'(MAX_WIDTH);

    // stage 1: input register
    logic                            r_v1;
    logic                            r_act1;
    logic [sspr_pkg::COORD_BITS-1:0] r_col1;
    logic [sspr_pkg::COORD_BITS-1:0] r_row1;
    logic [SAMPLE_BITS-1:0]          r_smp1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_act1 <= i_action;
            r_col1 <= i_col;
            r_row1 <= i_row;
            r_smp1 <= i_sample;
        end
    end

    // stage 2: checks, column wrap, row mirror
    logic [XW-1:0] w_x, h_x, p_x, c_x, r_x;
    logic [XW-1:0] wp_x, w2p_x, hp_x, h2p_x;
    logic          geom_ok, oob, wr_ok, is_rd;
    logic [XW-1:0] mc_x, mr_x;
    logic          pole;
    sspr_pkg::t_ctl n_ctl2;

    always_comb begin
        w_x   = XW'(i_map_width);
        h_x   = XW'(i_map_height);
        p_x   = XW'(i_pad_size);
        c_x   = XW'(r_col1);
        r_x   = XW'(r_row1);
        wp_x  = w_x + p_x;
        w2p_x = wp_x + p_x;
        hp_x  = h_x + p_x;
        h2p_x = hp_x + p_x;
        is_rd = (r_act1 == sspr_pkg::ACT_READ);

        geom_ok = (i_map_width != '0) && (32'(i_map_width) <= LIM_W) &&
                  (i_map_height != '0) && (32'(i_map_height) <= LIM_H) &&
                  (32'(i_pad_size) <= LIM_P) && (p_x <= w_x) && (p_x <= h_x);
        oob     = (c_x >= w2p_x) || (r_x >= h2p_x);
        wr_ok   = geom_ok && (c_x < w_x) && (r_x < h_x);

        if (!is_rd) begin
            mc_x = c_x;
        end else if (c_x < p_x) begin
            mc_x = w_x + c_x - p_x;
        end else if (c_x >= wp_x) begin
            mc_x = c_x - wp_x;
        end else begin
            mc_x = c_x - p_x;
        end

        pole = 1'b0;
        if (!is_rd) begin
            mr_x = r_x;
        end else if (r_x < p_x) begin
            mr_x = p_x - XW'(1) - r_x;
            pole = 1'b1;
        end else if (r_x >= hp_x) begin
            // h - 1 - (r - h - p)
            mr_x = (h_x << 1) + p_x - XW'(1) - r_x;
            pole = 1'b1;
        end else begin
            mr_x = r_x - p_x;
        end

        n_ctl2.valid = r_v1;
        n_ctl2.rd    = r_v1 && is_rd;
        n_ctl2.err   = r_v1 && is_rd && (!geom_ok || oob);
        n_ctl2.wr    = r_v1 && !is_rd && wr_ok;
        n_ctl2.pole  = is_rd && pole;
    end

    sspr_pkg::t_ctl  r_ctl2;
    logic [DW-1:0]   r_mc2, r_mr2;
    logic [SAMPLE_BITS-1:0] r_smp2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
        end else if (i_en) begin
            r_ctl2 <= n_ctl2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mc2  <= DW'(mc_x);
            r_mr2  <= DW'(mr_x);
            r_smp2 <= r_smp1;
        end
    end

    // stage 3: pole shift, (mc + w/2) mod w with one conditional subtract
    logic [XW-1:0] half_w, sum_x;
    logic [DW-1:0] n_mc3;

    always_comb begin
        half_w = XW'(i_map_width >> 1);
        sum_x  = XW'(r_mc2) + half_w;
        if (!r_ctl2.pole) begin
            n_mc3 = r_mc2;
        end else if (sum_x >= w_x) begin
            n_mc3 = DW'(sum_x - w_x);
        end else begin
            n_mc3 = DW'(sum_x);
        end
    end

    sspr_pkg::t_ctl  r_ctl3;
    logic [DW-1:0]   r_mc3, r_mr3;
    logic [SAMPLE_BITS-1:0] r_smp3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3 <= '0;
        end else if (i_en) begin
            r_ctl3 <= r_ctl2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mc3  <= n_mc3;
            r_mr3  <= r_mr2;
            r_smp3 <= r_smp2;
        end
    end

    // stage 4: linear address row * MAX_WIDTH + col
    logic [ADDR_BITS-1:0] n_addr;

    assign n_addr = ADDR_BITS'(r_mr3) * ROW_STRIDE + ADDR_BITS'(r_mc3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= r_ctl3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_addr   <= n_addr;
            o_sample <= r_smp3;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sphere_sheet_pad_remap.sv -----
// Path: a read word passes sspr_remap stages 1..4, the sample store and the result register before its result is valid.
// Throughput: one word per cycle; the whole pipe advances together and holds
// while a result word waits on the output register (set by the 1R1W store port).
// Reset: clears valid bits and loads map_width 256, map_height 128, pad_size 0.
// Store contents are not cleared; reading a never-written entry returns junk.
// Top level: config registers, sspr_remap pipeline, sample store, result register.
// Depends on sspr_pkg and sspr_remap.
`default_nettype none

module sphere_sheet_pad_remap #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int MAX_PAD     = 16,
    parameter int SAMPLE_BITS = 32
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    // configuration write port
    input  wire                                    i_cfg_we,
    input  wire  [sspr_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  wire  [sspr_pkg::DIM_BITS-1:0]          i_cfg_data,
    // input word stream
    input  wire                                    s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [8:0] col, [17:9] row, [17+SAMPLE_BITS:18] sample_in, zero fill above
    input  wire  [((2*sspr_pkg::COORD_BITS+SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // [0] action
    input  wire                                    s_axis_tuser,
    // result word stream
    output logic                                   m_axis_tvalid,
    input  wire                                    m_axis_tready,
    // [SAMPLE_BITS-1:0] sample_out, zero fill above
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,
    // [0] error
    output logic                                   m_axis_tuser
);

    localparam int CB         = sspr_pkg::COORD_BITS;
    localparam int OUT_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS  = $clog2(DEPTH);

    // ---------------- configuration registers ----------------
    logic [sspr_pkg::DIM_BITS-1:0] r_map_width;
    logic [sspr_pkg::DIM_BITS-1:0] r_map_height;
    logic [sspr_pkg::PAD_BITS-1:0] r_pad_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= sspr_pkg::RST_MAP_WIDTH;
            r_map_height <= sspr_pkg::RST_MAP_HEIGHT;
            r_pad_size   <= sspr_pkg::RST_PAD_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sspr_pkg::CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                sspr_pkg::CFG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                sspr_pkg::CFG_PAD_SIZE:   r_pad_size   <= i_cfg_data[sspr_pkg::PAD_BITS-1:0];
                default: ;  // unmapped index: dropped
            endcase
        end
    end

    // ---------------- pipeline enable ----------------
    // Global stall: everything moves unless a result word sits unclaimed.
    logic en;
    logic r_v5;
    logic r_err5;
    logic [SAMPLE_BITS-1:0] r_rdata;

    assign en            = !(r_v5 && !m_axis_tready);
    assign s_axis_tready = en;

    // ---------------- address remap, stages 1..4 ----------------
    sspr_pkg::t_ctl         ctl4;
    logic [ADDR_BITS-1:0]   addr4;
    logic [SAMPLE_BITS-1:0] smp4;

    sspr_remap #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_PAD     (MAX_PAD),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_remap (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (s_axis_tvalid),
        .i_action     (s_axis_tuser),
        .i_col        (s_axis_tdata[CB-1:0]),
        .i_row        (s_axis_tdata[2*CB-1:CB]),
        .i_sample     (s_axis_tdata[2*CB +: SAMPLE_BITS]),
        .i_map_width  (r_map_width),
        .i_map_height (r_map_height),
        .i_pad_size   (r_pad_size),
        .o_ctl        (ctl4),
        .o_addr       (addr4),
        .o_sample     (smp4)
    );

    // ---------------- stage 5: sample store ----------------
    // Writes and reads hit the store in word order, so a read sees every
    // earlier write; only one word occupies this stage per cycle.
    logic [SAMPLE_BITS-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (ctl4.valid && ctl4.wr) begin
                r_mem[addr4] <= smp4;
            end
            r_rdata <= r_mem[addr4];
        end
    end

    // result register: only reads produce a word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5   <= 1'b0;
            r_err5 <= 1'b0;
        end else if (en) begin
            r_v5   <= ctl4.valid && ctl4.rd;
            r_err5 <= ctl4.err;
        end
    end

    assign m_axis_tvalid = r_v5;
    assign m_axis_tuser  = r_err5;
    assign m_axis_tdata  = OUT_BITS'(r_err5 ? SAMPLE_BITS'(0) : r_rdata);

    // ---------------- assertions ----------------
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("error word carries nonzero sample");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && ctl4.valid && ctl4.wr |=> !m_axis_tvalid)
        else $error("store write produced a result word");

    a_ctl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl4.valid |-> !(ctl4.wr && ctl4.rd) && !(ctl4.err && !ctl4.rd))
        else $error("inconsistent control flags at store stage");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
